[rtl/sbc_pkg.sv]
// Shared types and constants for the sphere versus box contact pipeline.
// Depends on nothing; imported by sphere_box_contact and its testbench.
package sbc_pkg;

	localparam int CoordW = 24;
	localparam int UnsW = 23;
	localparam int NormW = 14;
	localparam int SumW = 50;
	localparam int RootW = 25;
	localparam int RemW = 27;
	localparam int SqrtSteps = 25;
	localparam int DivSteps = 23;
	localparam int NumW = 46;
	localparam int InW = 240;
	localparam int OutW = 192;
	localparam logic [CoordW-1:0] MaxPos = 24'h7FFFFF;
	localparam logic [CoordW-1:0] MaxNeg = 24'h800000;

	// Geometry that rides along the square root stages.
	typedef struct packed {
		logic [2:0][CoordW-1:0] point;
		logic [2:0][CoordW-1:0] dmag;
		logic [2:0] dneg;
		logic [UnsW-1:0] radius;
	} geom_t;

	// Geometry that rides along the divider stages.
	typedef struct packed {
		logic [2:0][CoordW-1:0] point;
		logic [2:0] dneg;
		logic hit;
		logic [UnsW-1:0] den;
	} divside_t;

	// Saturate a 26-bit signed sum to the 24-bit signed range.
	function automatic logic [CoordW-1:0] sat24(input logic signed [25:0] v);
		logic [CoordW-1:0] r;
		if (v > $signed(26'sd8388607)) r = MaxPos;
		else if (v < -$signed(26'sd8388608)) r = MaxNeg;
		else r = v[CoordW-1:0];
		return r;
	endfunction

endpackage

[rtl/sphere_box_contact.sv]
// Sphere versus axis-aligned box contact test, fully pipelined.
// Depends on sbc_pkg for widths, stage counts and carried structs.
//
// Usage:
// Input items arrive on the s_axis channel: one sphere (center, radius)
// and one box (center, half-extents) in Q11.12. Each item gives one result
// item on m_axis: hit in tuser, contact point, push vector and unit
// normal in tdata. On a miss all data fields are zero.
// There are 54 register stages: four front stages (bounds, clamp, squares,
// sum), 25 square root stages of one root bit each, one multiply stage,
// 23 divider stages of one quotient bit each for all six divisions, and
// the output register. Throughput is one item per cycle while the receiver
// does not stall; the shared stall enable and the one-bit-per-stage root
// and divider set that figure.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready falls; bubbles inside do not close up, since the pipeline
// advances only when the output register is empty or the receiver is ready.
// Reset clears all valid bits; no result is shown until items come in.
module sphere_box_contact
	import sbc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	// sphere_x, sphere_y, sphere_z, sphere_radius, box_x, box_y, box_z,
	// half_x, half_y, half_z, then zero fill
	input  logic [InW-1:0]  s_axis_tdata,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	// contact_x, contact_y, contact_z, push_x, push_y, push_z,
	// normal_x, normal_y, normal_z, then zero fill
	output logic [OutW-1:0] m_axis_tdata,
	// hit
	output logic [0:0]      m_axis_tuser
);

	logic en;
	logic out_valid_q;

	assign en = m_axis_tready | ~out_valid_q;
	assign s_axis_tready = en;

	// Unpack the input item.
	logic [2:0][CoordW-1:0] in_s, in_c;
	logic [2:0][UnsW-1:0] in_h;
	logic [UnsW-1:0] in_r;
	assign in_s[0] = s_axis_tdata[23:0];
	assign in_s[1] = s_axis_tdata[47:24];
	assign in_s[2] = s_axis_tdata[71:48];
	assign in_r    = s_axis_tdata[94:72];
	assign in_c[0] = s_axis_tdata[118:95];
	assign in_c[1] = s_axis_tdata[142:119];
	assign in_c[2] = s_axis_tdata[166:143];
	assign in_h[0] = s_axis_tdata[189:167];
	assign in_h[1] = s_axis_tdata[212:190];
	assign in_h[2] = s_axis_tdata[235:213];

	// Stage 1: saturated box bounds.
	logic v_s1;
	logic [2:0][CoordW-1:0] s_s1, lo_s1, hi_s1;
	logic [UnsW-1:0] r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				s_s1[a] <= in_s[a];
				lo_s1[a] <= sat24({{2{in_c[a][CoordW-1]}}, in_c[a]} - {3'b000, in_h[a]});
				hi_s1[a] <= sat24({{2{in_c[a][CoordW-1]}}, in_c[a]} + {3'b000, in_h[a]});
			end
			r_s1 <= in_r;
		end
	end

	// Stage 2: clamp into the box and take the difference.
	logic v_s2;
	geom_t g_s2;
	logic [2:0][CoordW-1:0] pt_c;
	logic [2:0][CoordW:0] d_c;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if ($signed(s_s1[a]) < $signed(lo_s1[a])) pt_c[a] = lo_s1[a];
			else if ($signed(s_s1[a]) > $signed(hi_s1[a])) pt_c[a] = hi_s1[a];
			else pt_c[a] = s_s1[a];
			d_c[a] = {s_s1[a][CoordW-1], s_s1[a]} - {pt_c[a][CoordW-1], pt_c[a]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				g_s2.point[a] <= pt_c[a];
				g_s2.dneg[a] <= d_c[a][CoordW];
				g_s2.dmag[a] <= d_c[a][CoordW] ? (~d_c[a][CoordW-1:0] + 1'b1)
					: d_c[a][CoordW-1:0];
			end
			g_s2.radius <= r_s1;
		end
	end

	// Stage 3: squares of the difference magnitudes.
	logic v_s3;
	geom_t g_s3;
	logic [2:0][2*CoordW-1:0] sq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) sq_s3[a] <= g_s2.dmag[a] * g_s2.dmag[a];
			g_s3 <= g_s2;
		end
	end

	// Stage 4: sum of squares.
	logic v_s4;
	geom_t g_s4;
	logic [SumW-1:0] sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};
			g_s4 <= g_s3;
		end
	end

	// Square root: one root bit per stage, two radicand bits consumed each.
	logic [SqrtSteps:0] rt_v;
	geom_t rt_g [SqrtSteps+1];
	logic [SumW-1:0] rt_n [SqrtSteps+1];
	logic [RemW-1:0] rt_rem [SqrtSteps+1];
	logic [RootW-1:0] rt_root [SqrtSteps+1];

	assign rt_v[0] = v_s4;
	assign rt_g[0] = g_s4;
	assign rt_n[0] = sum_s4;
	assign rt_rem[0] = '0;
	assign rt_root[0] = '0;

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
		logic [RemW+1:0] cur;
		logic [RemW+1:0] trial;
		logic ge;

		// The trial value is four times the partial root plus one.
		assign cur = {rt_rem[k], rt_n[k][SumW-1-2*k -: 2]};
		assign trial = {2'b00, rt_root[k], 2'b01};
		assign ge = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v[k+1] <= 1'b0;
			else if (en) rt_v[k+1] <= rt_v[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_g[k+1] <= rt_g[k];
				rt_n[k+1] <= rt_n[k];
				rt_root[k+1] <= {rt_root[k][RootW-2:0], ge};
				rt_rem[k+1] <= ge ? RemW'(cur - trial) : cur[RemW-1:0];
			end
		end
	end

	// Multiply stage: hit decision and rounded dividends.
	logic [RootW-1:0] dist_c;
	logic [UnsW-1:0] depth_c;
	logic hit_c;
	geom_t gr;

	assign dist_c = rt_root[SqrtSteps];
	assign gr = rt_g[SqrtSteps];
	assign hit_c = (dist_c != '0) && (dist_c < {2'b00, gr.radius});
	assign depth_c = gr.radius - dist_c[UnsW-1:0];

	logic v_m;
	divside_t side_m;
	logic [5:0][NumW-1:0] num_m;
	logic [CoordW+UnsW-1:0] prod_c [3];

	always_comb begin
		for (int a = 0; a < 3; a++) prod_c[a] = gr.dmag[a] * depth_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m <= 1'b0;
		else if (en) v_m <= rt_v[SqrtSteps];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				num_m[a] <= {10'd0, gr.dmag[a], 12'd0} + {22'd0, dist_c[RootW-1:1]};
				num_m[3+a] <= NumW'(prod_c[a]) + {22'd0, dist_c[RootW-1:1]};
			end
			side_m.point <= gr.point;
			side_m.dneg <= gr.dneg;
			side_m.hit <= hit_c;
			side_m.den <= dist_c[UnsW-1:0];
		end
	end

	// Dividers: six lanes, one quotient bit per stage each.
	logic [DivSteps:0] dv_v;
	divside_t dv_side [DivSteps+1];
	logic [5:0][NumW-1:0] dv_w [DivSteps+1];

	assign dv_v[0] = v_m;
	assign dv_side[0] = side_m;
	assign dv_w[0] = num_m;

	for (genvar k = 0; k < DivSteps; k++) begin : g_div
		logic [5:0][NumW-1:0] nxt;

		always_comb begin
			logic [UnsW:0] t;
			logic ge;
			for (int l = 0; l < 6; l++) begin
				t = dv_w[k][l][NumW-1:DivSteps-1];
				ge = t >= {1'b0, dv_side[k].den};
				nxt[l][NumW-1:DivSteps] = ge ? UnsW'(t - {1'b0, dv_side[k].den})
					: t[UnsW-1:0];
				nxt[l][DivSteps-1:0] = {dv_w[k][l][DivSteps-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[k+1] <= 1'b0;
			else if (en) dv_v[k+1] <= dv_v[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_side[k+1] <= dv_side[k];
				dv_w[k+1] <= nxt;
			end
		end
	end

	// Output register: apply signs and zero the fields on a miss.
	divside_t fs;
	logic [OutW-1:0] data_c;
	logic [DivSteps-1:0] qn, qp;

	assign fs = dv_side[DivSteps];

	always_comb begin
		data_c = '0;
		qn = '0;
		qp = '0;
		if (fs.hit) begin
			for (int a = 0; a < 3; a++) begin
				qn = dv_w[DivSteps][a][DivSteps-1:0];
				qp = dv_w[DivSteps][3+a][DivSteps-1:0];
				data_c[a*CoordW +: CoordW] = fs.point[a];
				data_c[3*CoordW + a*CoordW +: CoordW] = fs.dneg[a]
					? (~{1'b0, qp} + 1'b1) : {1'b0, qp};
				data_c[6*CoordW + a*NormW +: NormW] = fs.dneg[a]
					? (~{1'b0, qn[NormW-2:0]} + 1'b1) : {1'b0, qn[NormW-2:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= dv_v[DivSteps];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= data_c;
			m_axis_tuser[0] <= fs.hit;
		end
	end

	assign m_axis_tvalid = out_valid_q;

endmodule

[tb/sphere_box_contact_test.sv]
// Self-checking testbench for the sphere versus box contact pipeline.
// Depends on sbc_pkg and sphere_box_contact; predicts each result item in a scoreboard class.
`timescale 1ns / 100ps

module sphere_box_contact_test
	import sbc_pkg::*;
();

	// One predicted result item.
	typedef struct {
		logic hit;
		logic [2:0][CoordW-1:0] contact;
		logic [2:0][CoordW-1:0] push;
		logic [2:0][NormW-1:0] normal;
	} contact_t;

	// One input item.
	typedef struct {
		logic signed [2:0][CoordW-1:0] center;
		logic [UnsW-1:0] radius;
		logic signed [2:0][CoordW-1:0] box;
		logic [2:0][UnsW-1:0] half;
	} pair_t;

	// Predicts contact results and checks them in order.
	class contact_board;
		contact_t pending[$];
		int errors;

		function longint unsigned isqrt(longint unsigned n);
			longint unsigned root, bitv;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv >>= 2;
			while (bitv != 0) begin
				if (n >= root + bitv) begin
					n -= root + bitv;
					root = (root >> 1) + bitv;
				end else begin
					root >>= 1;
				end
				bitv >>= 2;
			end
			return root;
		endfunction

		// Round to nearest with ties away from zero.
		function longint rdiv(longint num, longint den);
			longint mag, q;
			mag = (num < 0) ? -num : num;
			q = (mag + den / 2) / den;
			return (num < 0) ? -q : q;
		endfunction

		function void note_pair(pair_t p);
			contact_t r;
			longint s, c, h, lo, hi, pt[3], d[3], distance, depth;
			longint unsigned sumsq;
			sumsq = 0;
			for (int a = 0; a < 3; a++) begin
				s = $signed(p.center[a]);
				c = $signed(p.box[a]);
				h = p.half[a];
				lo = c - h;
				hi = c + h;
				if (lo < -8388608) lo = -8388608;
				if (hi > 8388607) hi = 8388607;
				pt[a] = (s < lo) ? lo : (s > hi) ? hi : s;
				d[a] = s - pt[a];
				sumsq += d[a] * d[a];
			end
			distance = isqrt(sumsq);
			r.hit = 0;
			r.contact = '0;
			r.push = '0;
			r.normal = '0;
			if (distance != 0 && distance < p.radius) begin
				depth = p.radius - distance;
				r.hit = 1;
				for (int a = 0; a < 3; a++) begin
					r.contact[a] = CoordW'(pt[a]);
					r.push[a] = CoordW'(rdiv(d[a] * depth, distance));
					r.normal[a] = NormW'(rdiv(d[a] * 4096, distance));
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [OutW-1:0] data, logic hit);
			contact_t e;
			if (pending.size() == 0) begin
				$error("result item with no expectation");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (hit !== e.hit) begin
				$error("hit: expected %0d actual %0d", e.hit, hit);
				errors++;
			end
			for (int a = 0; a < 3; a++) begin
				if (data[a*CoordW +: CoordW] !== e.contact[a]) begin
					$error("contact_%0d: expected %h actual %h", a, e.contact[a],
						data[a*CoordW +: CoordW]);
					errors++;
				end
				if (data[(3+a)*CoordW +: CoordW] !== e.push[a]) begin
					$error("push_%0d: expected %h actual %h", a, e.push[a],
						data[(3+a)*CoordW +: CoordW]);
					errors++;
				end
				if (data[6*CoordW + a*NormW +: NormW] !== e.normal[a]) begin
					$error("normal_%0d: expected %h actual %h", a, e.normal[a],
						data[6*CoordW + a*NormW +: NormW]);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// sphere_x, sphere_y, sphere_z, sphere_radius, box_x, box_y, box_z, half_x, half_y, half_z
	logic [InW-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// contact_x, contact_y, contact_z, push_x, push_y, push_z, normal_x, normal_y, normal_z
	logic [OutW-1:0] m_axis_tdata;
	// hit
	logic [0:0] m_axis_tuser;

	contact_board board;
	int cycles;
	bit hold_long;

	sphere_box_contact u_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Pack the fields, first field lowest.
	function automatic logic [InW-1:0] pack_pair(pair_t p);
		return {4'd0, p.half[2], p.half[1], p.half[0], p.box[2], p.box[1], p.box[0],
			p.radius, p.center[2], p.center[1], p.center[0]};
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60) return 0;
		if (k < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one item and hold it until accepted; valid stays high between
	// items sent with no gap.
	task automatic send_pair(pair_t p, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			s_axis_tvalid <= 0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= pack_pair(p);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_pair(p);
		@(negedge clk);
	endtask

	function automatic logic [CoordW-1:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'($signed($urandom_range(0, 8000)) - 4000);
			default: return 24'($urandom);
		endcase
	endfunction

	// Random pair, mostly placed so the sphere is near the box to get hits.
	function automatic pair_t rnd_pair();
		pair_t p;
		int mode;
		mode = $urandom_range(0, 9);
		for (int a = 0; a < 3; a++) begin
			p.box[a] = rnd_coord();
			p.half[a] = (mode < 7) ? 23'($urandom_range(0, 20000)) : 23'($urandom);
			if (mode < 7)
				p.center[a] = p.box[a] + 24'($signed($urandom_range(0, 60000)) - 30000);
			else
				p.center[a] = rnd_coord();
		end
		p.radius = (mode < 7) ? 23'($urandom_range(0, 40000)) : 23'($urandom);
		return p;
	endfunction

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				m_axis_tready <= 0;
				repeat (200) @(negedge clk);
				hold_long = 0;
			end
			m_axis_tready <= ($urandom_range(0, 99) < 75) || (cycles % 2000 < 300);
		end
	end

	always @(posedge clk)
		if (m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tuser[0]);

	// Cycle limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		pair_t p;
		int guard;
		board = new();
		cycles = 0;
		hold_long = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: center inside the box, zero radius, saturated bounds, extremes.
		for (int i = 0; i < 24; i++) begin
			for (int a = 0; a < 3; a++) begin
				p.center[a] = (i % 3 == 0) ? 24'h800000 : (i % 3 == 1) ? 24'h7FFFFF : 24'd0;
				p.box[a] = (i % 4 == 0) ? 24'h7FFFFF : (i % 4 == 1) ? 24'h800000 : 24'd4096;
				p.half[a] = (i % 5 == 0) ? 23'h7FFFFF : (i % 5 == 1) ? 23'd0 : 23'd1000;
			end
			p.radius = (i % 6 == 0) ? 23'd0 : (i % 6 == 1) ? 23'h7FFFFF : 23'd5000;
			if (i == 20) begin
				p.center = '{24'd3000, 24'd0, 24'd0};
				p.box = '0;
				p.half = '{23'd1000, 23'd1000, 23'd1000};
				p.radius = 23'd4000;
			end
			send_pair(p, 0);
		end

		// Random part, with one long receiver hold-off and one drain pause.
		for (int i = 0; i < 1300; i++) begin
			if (i == 300) hold_long = 1;
			if (i == 700) begin
				s_axis_tvalid <= 0;
				while (board.pending.size() != 0) @(negedge clk);
			end
			send_pair(rnd_pair(), i > 400 || i < 300);
		end
		s_axis_tvalid <= 0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
